// ===== src/fhbm_pkg.sv =====
// Package with the shared types, constants and codes of the folded Hamming best-match core.
`timescale 1ns / 1ps
package fhbm_pkg;

  localparam int MAX_SETS     = 512;
  localparam int VECTOR_WORDS = 16;
  localparam int WORD_BITS    = 64;

  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int WORD_W   = $clog2(VECTOR_WORDS);
  localparam int TAB_AW   = SET_W + WORD_W;
  localparam int TAB_DEPTH = MAX_SETS * VECTOR_WORDS;
  localparam int POP_W    = $clog2(WORD_BITS + 1);
  localparam int DIST_W   = $clog2(VECTOR_WORDS * WORD_BITS + 1);

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int NET_W     = 10;
  localparam int COST_W    = 31;
  localparam int TAG_W     = 16;
  localparam int UNF_W     = 12;

  localparam logic [COST_W-1:0] COST_NONE  = 31'h7fff_ffff;
  localparam logic [COST_W-1:0] COST_SCALE = 31'd10000;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPECIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS    = 1'b1;

  typedef struct packed {
    logic [1:0]           op;
    logic [SET_W-1:0]     entry;
    logic [WORD_W-1:0]    word_index;
    logic [WORD_BITS-1:0] data;
    logic                 last_word;
    logic                 remember;
    logic [UNF_W-1:0]     unfound;
    logic [TAG_W-1:0]     tag;
  } in_beat_t;

  typedef struct packed {
    logic              found;
    logic [SET_W-1:0]  best_entry;
    logic [NET_W-1:0]  net_dist;
    logic [COST_W-1:0] stored_cost;
    logic [TAG_W-1:0]  stored_tag;
    logic              tag_valid;
  } out_beat_t;

  // One remembered match, as kept in the match memory.
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [TAG_W-1:0]  tag;
    logic              valid;
  } match_t;

  localparam match_t MATCH_CLEAR = '{cost: COST_NONE, tag: '0, valid: 1'b0};

  // Marks the table word that enters the distance unit in this cycle.
  typedef struct packed {
    logic             v;
    logic             last;
    logic [SET_W-1:0] ent;
  } scan_tap_t;

  typedef struct packed {
    logic             busy;
    logic [SET_W-1:0] ent;
    logic [NET_W-1:0] cost;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MREAD,
    ST_OUT
  } fsm_state_t;

endpackage

// ===== src/fhbm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module fhbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== src/fhbm_scan_unit.sv =====
// Distance unit: popcount of one word per cycle, per-entry sum, folding and best-entry compare.
`timescale 1ns / 1ps
module fhbm_scan_unit
  import fhbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CFG_W-1:0]     species_count,
  input  scan_tap_t            tap,
  input  logic [WORD_BITS-1:0] pat_word,
  input  logic [WORD_BITS-1:0] qry_word,
  output scan_res_t            res
);

  // Pairwise reduction: bit pairs, nibbles, bytes, then the bytes are folded together.
  function automatic logic [POP_W-1:0] popcount(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] s;
    s = x - ((x >> 1) & 64'h5555_5555_5555_5555);
    s = (s & 64'h3333_3333_3333_3333) + ((s >> 2) & 64'h3333_3333_3333_3333);
    s = (s + (s >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
    s = s + (s >> 8);
    s = s + (s >> 16);
    s = s + (s >> 32);
    return s[POP_W-1:0];
  endfunction

  logic [POP_W-1:0]  pop_r;
  scan_tap_t         a_tap_r;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] sum_r;
  logic              s_v_r;
  logic [SET_W-1:0]  s_ent_r;
  logic              any_r;
  logic [SET_W-1:0]  best_ent_r;
  logic [NET_W-1:0]  win_cost_r;

  logic [DIST_W-1:0] acc_sum;
  logic [DIST_W-1:0] species_ext;
  logic [DIST_W-1:0] half_ext;
  logic [NET_W-1:0]  folded;

  assign acc_sum     = acc_r + DIST_W'(pop_r);
  assign species_ext = DIST_W'(species_count);
  assign half_ext    = DIST_W'(species_count >> 1);

  // Distances above half the species count fold back; beyond the count they saturate at zero.
  always_comb begin
    if (sum_r > half_ext) begin
      if (sum_r > species_ext) begin
        folded = '0;
      end else begin
        folded = NET_W'(species_ext - sum_r);
      end
    end else begin
      folded = NET_W'(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tap_r.v <= 1'b0;
      s_v_r     <= 1'b0;
      any_r     <= 1'b0;
      acc_r     <= '0;
    end else begin
      a_tap_r <= tap;
      s_v_r   <= a_tap_r.v && a_tap_r.last;
      if (start) begin
        acc_r <= '0;
        any_r <= 1'b0;
      end else begin
        if (a_tap_r.v) begin
          acc_r <= a_tap_r.last ? '0 : acc_sum;
        end
        if (s_v_r && (!any_r || folded < win_cost_r)) begin
          any_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_r   <= popcount(pat_word ^ qry_word);
    sum_r   <= acc_sum;
    s_ent_r <= a_tap_r.ent;
    if (s_v_r && (!any_r || folded < win_cost_r)) begin
      best_ent_r <= s_ent_r;
      win_cost_r <= folded;
    end
  end

  assign res = '{busy: tap.v || a_tap_r.v || s_v_r, ent: best_ent_r, cost: win_cost_r};

endmodule

// ===== src/folded_hamming_best_match_core.sv =====
// Top level of the folded Hamming best-match core: sequencer, table memories and result register.
`timescale 1ns / 1ps
// The core keeps 512 stored bit-vectors of 16 words of 64 bits and finds, for a query vector,
// the stored entry with the smallest folded Hamming distance. A load beat or a query word
// without last_word is taken and gives no result. A read beat looks up its entry in the match
// memory and presents what is stored there. A query word with last_word set starts a
// search over the first sets_in_use entries, from the highest index down; the single read
// port of the pattern table delivers one 64-bit word per cycle; after the scan the pipeline
// drains, the winner's remembered match is looked up and the result is loaded. A search of
// an empty table skips the scan and answers with an all-zero beat. While a search or read
// runs, and while its result waits for a stalled output register, in_stall stays high.
// After reset the core clears its remembered-match memory, one entry per cycle, with
// in_stall high; the configuration port is live throughout. Once a finished result sits
// in the output register, the core takes new beats while that result waits to be taken.
module folded_hamming_best_match_core
  import fhbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_beat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  fsm_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  species_r;
  logic [CFG_W-1:0]  sets_r;
  logic [SET_W-1:0]  clr_r;
  logic [SET_W-1:0]  ent_r;
  logic [WORD_W-1:0] wrd_r;
  scan_tap_t         tap_r;

  // Parameters of the beat that started the current search or read.
  logic              is_read_r;
  logic              empty_r;
  logic [SET_W-1:0]  entry_r;
  logic              remember_r;
  logic [UNF_W-1:0]  unfound_r;
  logic [TAG_W-1:0]  tag_r;
  logic [COST_W-1:0] scaled_r;

  logic [WORD_BITS-1:0] qv_r [VECTOR_WORDS];
  logic [WORD_BITS-1:0] q_word_r;

  out_beat_t out_r;
  logic      out_valid_r;

  logic in_acc;
  logic out_free;
  logic out_load;
  logic scan_start;
  logic upd;

  logic [SET_W-1:0] start_ent;

  logic                 tab_we;
  logic [TAB_AW-1:0]    tab_waddr;
  logic                 tab_re;
  logic [TAB_AW-1:0]    tab_raddr;
  logic [WORD_BITS-1:0] tab_rdata;

  logic             m_we;
  logic [SET_W-1:0] m_waddr;
  match_t           m_wdata;
  logic             m_re;
  logic [SET_W-1:0] m_raddr;
  match_t           m_rdata;

  scan_res_t scan_res;
  out_beat_t out_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // The last entry scanned first: sets_in_use minus one, limited to the table size.
  assign start_ent = (sets_r >= CFG_W'(MAX_SETS)) ? SET_W'(MAX_SETS - 1)
                                                  : SET_W'(sets_r - CFG_W'(1));

  assign upd = !is_read_r && !empty_r && remember_r && (scaled_r < m_rdata.cost);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == SET_W'(MAX_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && in_beat.op == OP_READ) begin
          state_nxt = ST_MREAD;
        end else if (in_acc && in_beat.op == OP_QUERY && in_beat.last_word) begin
          state_nxt = (sets_r == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (wrd_r == WORD_W'(VECTOR_WORDS - 1) && ent_r == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!scan_res.busy) begin
          state_nxt = ST_MREAD;
        end
      end
      ST_MREAD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    in_stall   = 1'b1;
    tab_we     = 1'b0;
    tab_waddr  = {in_beat.entry, in_beat.word_index};
    tab_re     = 1'b0;
    tab_raddr  = {ent_r, wrd_r};
    m_we       = 1'b0;
    m_waddr    = in_beat.entry;
    m_wdata    = MATCH_CLEAR;
    m_re       = 1'b0;
    m_raddr    = is_read_r ? entry_r : scan_res.ent;
    scan_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc && in_beat.op == OP_LOAD) begin
          tab_we = 1'b1;
          // Loading the first word of an entry starts it afresh.
          m_we   = (in_beat.word_index == '0);
        end
        scan_start = in_acc && in_beat.op == OP_QUERY && in_beat.last_word;
      end
      ST_SCAN: begin
        tab_re = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_MREAD: begin
        m_re = 1'b1;
      end
      ST_OUT: begin
        out_load = out_free;
        m_we     = out_free && upd;
        m_waddr  = scan_res.ent;
        m_wdata  = '{cost: scaled_r, tag: tag_r, valid: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Result beat: an empty table gives all zeros, a read reports the entry as stored.
  always_comb begin
    out_nxt = '0;
    if (!empty_r) begin
      out_nxt.found       = 1'b1;
      out_nxt.best_entry  = is_read_r ? entry_r : scan_res.ent;
      out_nxt.net_dist    = is_read_r ? '0 : scan_res.cost;
      out_nxt.stored_cost = upd ? scaled_r : m_rdata.cost;
      out_nxt.stored_tag  = upd ? tag_r : m_rdata.tag;
      out_nxt.tag_valid   = upd ? 1'b1 : m_rdata.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      species_r   <= '0;
      sets_r      <= '0;
      tap_r.v     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + SET_W'(1);
      end
      if (cfg_we && cfg_index == CFG_SPECIES) begin
        species_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_SETS) begin
        sets_r <= cfg_wdata;
      end
      tap_r.v    <= (state_r == ST_SCAN);
      tap_r.last <= (wrd_r == WORD_W'(VECTOR_WORDS - 1));
      tap_r.ent  <= ent_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_beat.op == OP_QUERY) begin
      qv_r[in_beat.word_index] <= in_beat.data;
    end
    if (in_acc && (in_beat.op == OP_READ || in_beat.op == OP_QUERY)) begin
      is_read_r  <= (in_beat.op == OP_READ);
      empty_r    <= (in_beat.op == OP_QUERY) && (sets_r == '0);
      entry_r    <= in_beat.entry;
      remember_r <= in_beat.remember;
      unfound_r  <= in_beat.unfound;
      tag_r      <= in_beat.tag;
    end
    if (scan_start) begin
      ent_r <= start_ent;
      wrd_r <= '0;
    end else if (state_r == ST_SCAN) begin
      wrd_r <= wrd_r + WORD_W'(1);
      if (wrd_r == WORD_W'(VECTOR_WORDS - 1)) begin
        ent_r <= ent_r - SET_W'(1);
      end
    end
    // The query word is registered alongside the table read so both reach the unit together.
    q_word_r <= qv_r[wrd_r];
    if (state_r == ST_MREAD) begin
      scaled_r <= COST_W'(scan_res.cost) * COST_SCALE + COST_W'(unfound_r);
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  fhbm_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(TAB_DEPTH)
  ) u_pattern_ram (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(in_beat.data),
    .re   (tab_re),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  fhbm_ram #(
    .WIDTH($bits(match_t)),
    .DEPTH(MAX_SETS)
  ) u_match_ram (
    .clk  (clk),
    .we   (m_we),
    .waddr(m_waddr),
    .wdata(m_wdata),
    .re   (m_re),
    .raddr(m_raddr),
    .rdata(m_rdata)
  );

  fhbm_scan_unit u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (scan_start),
    .species_count(species_r),
    .tap          (tap_r),
    .pat_word     (tab_rdata),
    .qry_word     (q_word_r),
    .res          (scan_res)
  );

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  // The pattern table is only read while the search walks the entries.
  a_tab_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tab_re |-> state_r == ST_SCAN)
    else $error("pattern table read outside of a search");

  // The winner is looked up only once the distance pipeline has run dry.
  a_drained_before_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MREAD && !is_read_r) |-> !scan_res.busy)
    else $error("match lookup started with distance pipeline still busy");

  // A loaded result is presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("pending result overwritten");

endmodule

// ===== test/tb_folded_hamming_best_match_core.sv =====
// Self-checking testbench for the folded Hamming best-match core.
`timescale 1ns / 1ps
// The bench keeps its own mirror of the pattern table, the query vector and the remembered
// matches. Every accepted input beat is applied to that mirror, and reads and searches
// produce the expected result beat. A checker process compares each accepted result beat
// with the oldest expectation. Named test tasks run in turn: reset contents and the empty
// table, loading of the first few entries, an exact match with its remembered cost and tag,
// distance folding at several species counts, and then random traffic over the loaded
// entries. Both handshakes idle in random bursts, except in the last random phase. A
// watchdog stops a run that hangs.
module tb_folded_hamming_best_match_core;
  import fhbm_pkg::*;

  // Op code 3 has no meaning to the core and must be dropped without a result.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Searches never reach past the entries that the bench has loaded.
  localparam int LOADED_SETS = 3;

  // The longest quiet stretch of a correct run is the clearing pass after reset; searches
  // over the loaded entries, output stalls and sender gaps stay far below that, so the
  // watchdog allows several times that stretch.
  localparam int WATCHDOG_LIMIT = 5000;
  // Pipeline drain of a search plus the read path, with margin.
  localparam int SETTLE_CYCLES  = 16;
  localparam int REPORT_LIMIT   = 10;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_beat   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  folded_hamming_best_match_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Mirror of the core's state, kept in step with every accepted beat.
  logic [WORD_BITS-1:0] pattern_mirror [MAX_SETS][VECTOR_WORDS];
  logic [WORD_BITS-1:0] query_mirror [VECTOR_WORDS];
  logic [COST_W-1:0]    cost_mirror [MAX_SETS];
  logic [TAG_W-1:0]     tag_mirror [MAX_SETS];
  logic                 valid_mirror [MAX_SETS];
  logic [CFG_W-1:0]     species_reg;
  logic [CFG_W-1:0]     sets_reg;
  int                   last_winner = 0;

  out_beat_t expected_matches [$];

  int failures     = 0;
  int quiet_cycles = 0;
  int beats_sent   = 0;
  int stall_left   = 0;
  bit idle_en      = 1'b1;

  function automatic string beat_text(input out_beat_t r);
    return $sformatf("found=%0d entry=%0d net=%0d cost=%0h tag=%0h tag_valid=%0d",
                     r.found, r.best_entry, r.net_dist, r.stored_cost, r.stored_tag,
                     r.tag_valid);
  endfunction

  function automatic void report_failure(input string msg);
    if (failures < REPORT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    failures++;
  endfunction

  task automatic reset_mirror();
    for (int e = 0; e < MAX_SETS; e++) begin
      cost_mirror[e]  = COST_NONE;
      tag_mirror[e]   = '0;
      valid_mirror[e] = 1'b0;
      for (int w = 0; w < VECTOR_WORDS; w++) begin
        pattern_mirror[e][w] = '0;
      end
    end
    for (int w = 0; w < VECTOR_WORDS; w++) begin
      query_mirror[w] = '0;
    end
    species_reg = '0;
    sets_reg    = '0;
  endtask

  // Applies one accepted beat to the mirror and queues the result beat it causes, if any.
  task automatic compute_expected_match(input in_beat_t b);
    out_beat_t   r;
    int unsigned n;
    int unsigned half;
    int unsigned hd;
    int unsigned win_dist;
    int unsigned scaled;
    int          best;
    int          i;
    bit          any;
    r = '0;
    case (b.op)
      OP_LOAD: begin
        pattern_mirror[b.entry][b.word_index] = b.data;
        // Rewriting the first word means a new entry, so its match history is dropped.
        if (b.word_index == 0) begin
          cost_mirror[b.entry]  = COST_NONE;
          tag_mirror[b.entry]   = '0;
          valid_mirror[b.entry] = 1'b0;
        end
      end
      OP_READ: begin
        r.found       = 1'b1;
        r.best_entry  = b.entry;
        r.stored_cost = cost_mirror[b.entry];
        r.stored_tag  = tag_mirror[b.entry];
        r.tag_valid   = valid_mirror[b.entry];
        expected_matches.push_back(r);
      end
      OP_QUERY: begin
        query_mirror[b.word_index] = b.data;
        if (b.last_word) begin
          n        = (sets_reg > MAX_SETS) ? MAX_SETS : sets_reg;
          half     = species_reg / 2;
          any      = 1'b0;
          best     = 0;
          win_dist = 0;
          // Scan from the top down; only a strictly smaller distance replaces the
          // current winner, so ties stay with the higher index.
          for (i = int'(n) - 1; i >= 0; i--) begin
            hd = 0;
            for (int w = 0; w < VECTOR_WORDS; w++) begin
              hd += $countones(query_mirror[w] ^ pattern_mirror[i][w]);
            end
            if (hd > half) begin
              hd = (hd > species_reg) ? 0 : species_reg - hd;
            end
            if (!any || hd < win_dist) begin
              any      = 1'b1;
              win_dist = hd;
              best     = i;
            end
          end
          if (any) begin
            scaled = win_dist * COST_SCALE + b.unfound;
            if (b.remember && scaled < cost_mirror[best]) begin
              cost_mirror[best]  = COST_W'(scaled);
              tag_mirror[best]   = b.tag;
              valid_mirror[best] = 1'b1;
            end
            r.found       = 1'b1;
            r.best_entry  = SET_W'(best);
            r.net_dist    = NET_W'(win_dist);
            r.stored_cost = cost_mirror[best];
            r.stored_tag  = tag_mirror[best];
            r.tag_valid   = valid_mirror[best];
            last_winner   = best;
          end
          // An empty table still answers, with an all-zero beat.
          expected_matches.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endtask

  // A beat of the given op with every field random; callers override what matters.
  function automatic in_beat_t noise_beat(input logic [1:0] op);
    in_beat_t b;
    b.op         = op;
    b.entry      = SET_W'($urandom);
    b.word_index = WORD_W'($urandom);
    b.data       = {$urandom, $urandom};
    b.last_word  = 1'($urandom);
    b.remember   = 1'($urandom);
    b.unfound    = UNF_W'($urandom);
    b.tag        = TAG_W'($urandom);
    return b;
  endfunction

  // A last query word that rewrites word 0 with its current value, so the search runs
  // on the query vector as it stands.
  function automatic in_beat_t search_beat(input bit rem, input logic [UNF_W-1:0] unf,
                                           input logic [TAG_W-1:0] tg);
    in_beat_t b;
    b            = noise_beat(OP_QUERY);
    b.word_index = '0;
    b.data       = query_mirror[0];
    b.last_word  = 1'b1;
    b.remember   = rem;
    b.unfound    = unf;
    b.tag        = tg;
    return b;
  endfunction

  // Sends one beat: an optional random gap with valid low, then valid high with the
  // payload held until the core takes it at a rising edge with in_stall low.
  task automatic send_beat(input in_beat_t b);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_beat  = b;
    do @(posedge clk); while (in_stall !== 1'b0);
    compute_expected_match(b);
    if (b.op != OP_UNUSED) begin
      beats_sent++;
    end
  endtask

  // Drops valid and holds off until every expected result has arrived and the core has
  // had time to finish any beat that gives no result.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_for_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SPECIES) begin
      species_reg = value[CFG_W-1:0];
    end else begin
      sets_reg = value[CFG_W-1:0];
    end
  endtask

  task automatic configure(input int unsigned species, input int unsigned sets);
    write_reg(CFG_SPECIES, species);
    write_reg(CFG_SETS, sets);
  endtask

  // Writes query words copied from one stored entry, with a flipped bit or a random word
  // now and then, and starts a search on the last of them. A full-length run writes
  // every word in order; a shorter one picks random words.
  task automatic query_near_entry(input int e, input int words, input bit exact,
                                  input bit rem, input logic [UNF_W-1:0] unf,
                                  input logic [TAG_W-1:0] tg);
    in_beat_t b;
    int       k;
    for (int i = 0; i < words; i++) begin
      b = noise_beat(OP_QUERY);
      if (words == VECTOR_WORDS) begin
        b.word_index = WORD_W'(i);
      end
      b.data = pattern_mirror[e][b.word_index];
      if (!exact && $urandom_range(0, 1) == 1) begin
        k         = $urandom_range(0, WORD_BITS - 1);
        b.data[k] = ~b.data[k];
      end
      if (!exact && $urandom_range(0, 5) == 0) begin
        b.data = {$urandom, $urandom};
      end
      b.last_word = (i == words - 1);
      b.remember  = rem;
      b.unfound   = unf;
      b.tag       = tg;
      send_beat(b);
    end
  endtask

  // Reset contents: the first and last entries read back with no match, and a search over an
  // empty table answers with zeros and leaves the matches alone.
  task automatic test_empty_table();
    in_beat_t b;
    configure(0, 0);
    b = noise_beat(OP_READ);
    b.entry = '0;
    send_beat(b);
    b = noise_beat(OP_READ);
    b.entry = '1;
    send_beat(b);
    send_beat(noise_beat(OP_UNUSED));
    b = noise_beat(OP_QUERY);
    b.word_index = WORD_W'(VECTOR_WORDS - 1);
    b.last_word  = 1'b1;
    b.remember   = 1'b1;
    b.unfound    = '0;
    b.tag        = '1;
    send_beat(b);
    b = noise_beat(OP_QUERY);
    b.last_word = 1'b0;
    send_beat(b);
    b = noise_beat(OP_READ);
    b.entry = '1;
    send_beat(b);
    wait_for_results();
  endtask

  // Fills every word of the entries that searches scan, so no search can ever touch an
  // unwritten word. The first entry is all zeros and the last loaded one all ones.
  task automatic load_test_entries();
    in_beat_t b;
    for (int e = 0; e < LOADED_SETS; e++) begin
      for (int w = 0; w < VECTOR_WORDS; w++) begin
        b            = noise_beat(OP_LOAD);
        b.entry      = SET_W'(e);
        b.word_index = WORD_W'(w);
        if (e == 0) begin
          b.data = '0;
        end else if (e == LOADED_SETS - 1) begin
          b.data = '1;
        end
        send_beat(b);
      end
    end
    wait_for_results();
  endtask

  // A query equal to one entry wins at distance zero. A lower penalty replaces the
  // remembered tag, an equal one does not, a search without remember leaves it, and a
  // rewrite of word 0 clears it.
  task automatic test_exact_match();
    in_beat_t b;
    configure(1023, LOADED_SETS);
    query_near_entry(1, VECTOR_WORDS, 1'b1, 1'b1, '1, '1);
    send_beat(search_beat(1'b1, '0, 16'h1234));
    send_beat(search_beat(1'b1, '0, 16'h4321));
    send_beat(search_beat(1'b0, '0, 16'h0bad));
    b = noise_beat(OP_READ);
    b.entry = SET_W'(1);
    send_beat(b);
    b            = noise_beat(OP_LOAD);
    b.entry      = SET_W'(1);
    b.word_index = '0;
    b.data       = pattern_mirror[1][0];
    send_beat(b);
    b = noise_beat(OP_READ);
    b.entry = SET_W'(1);
    send_beat(b);
    wait_for_results();
  endtask

  // With no species every distance folds to zero and the highest entry wins the tie.
  // A small species count pushes distances past it, where they saturate at zero.
  task automatic test_distance_folding();
    configure(0, LOADED_SETS);
    send_beat(search_beat(1'b1, UNF_W'($urandom), TAG_W'($urandom)));
    configure(10, LOADED_SETS);
    send_beat(search_beat(1'b1, UNF_W'($urandom), TAG_W'($urandom)));
    configure(1, 1);
    send_beat(search_beat(1'b1, UNF_W'($urandom), TAG_W'($urandom)));
    configure(1023, 2);
    send_beat(search_beat(1'b1, UNF_W'($urandom), TAG_W'($urandom)));
    wait_for_results();
  endtask

  // The largest share is query runs built from stored entries, so that searches land close
  // and the remembered matches move; the rest is loads, reads, stray query words and dead ops.
  task automatic test_random_traffic(input int unsigned species, input int unsigned sets,
                                     input int count);
    in_beat_t b;
    int       n_scan;
    int       start;
    int       pick;
    configure(species, sets);
    n_scan = (sets > MAX_SETS) ? MAX_SETS : sets;
    start  = beats_sent;
    while (beats_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        query_near_entry($urandom_range(0, n_scan - 1), $urandom_range(1, 4), 1'b0,
                         $urandom_range(0, 3) != 0, UNF_W'($urandom_range(0, 4095)),
                         TAG_W'($urandom));
      end else if (pick < 55) begin
        b = noise_beat(OP_LOAD);
        if ($urandom_range(0, 1) == 1) begin
          b.entry = SET_W'($urandom_range(0, n_scan - 1));
        end
        if ($urandom_range(0, 1) == 1) begin
          b.data = query_mirror[b.word_index] ^ (64'd1 << $urandom_range(0, WORD_BITS - 1));
        end
        send_beat(b);
      end else if (pick < 75) begin
        b = noise_beat(OP_READ);
        if ($urandom_range(0, 1) == 1) begin
          b.entry = SET_W'(last_winner);
        end
        send_beat(b);
      end else if (pick < 95) begin
        send_beat(noise_beat(OP_QUERY));
      end else begin
        send_beat(noise_beat(OP_UNUSED));
      end
    end
    wait_for_results();
  endtask

  // Result side back-pressure: random stall bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 15);
    end
    out_stall = (stall_left != 0);
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_matches.size() == 0) begin
        report_failure({"result with nothing expected: ", beat_text(out_beat)});
      end else begin
        want = expected_matches.pop_front();
        if (out_beat.found !== want.found || out_beat.best_entry !== want.best_entry ||
            out_beat.net_dist !== want.net_dist ||
            out_beat.stored_cost !== want.stored_cost ||
            out_beat.stored_tag !== want.stored_tag ||
            out_beat.tag_valid !== want.tag_valid) begin
          report_failure({"expected ", beat_text(want), ", got ", beat_text(out_beat)});
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_folded_hamming_best_match_core failed");
      $finish;
    end
  end

  initial begin
    reset_mirror();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    load_test_entries();
    test_exact_match();
    test_distance_folding();

    test_random_traffic(1023, LOADED_SETS, 6);
    test_random_traffic(0, 2, 4);
    test_random_traffic($urandom_range(2, 1022), $urandom_range(1, LOADED_SETS), 6);
    test_random_traffic(1, 1, 3);
    // The closing phase runs with both sides at full rate.
    idle_en = 1'b0;
    test_random_traffic($urandom_range(2, 1022), $urandom_range(2, LOADED_SETS), 8);

    if (failures == 0) begin
      $display("tb_folded_hamming_best_match_core passed");
    end else begin
      $display("tb_folded_hamming_best_match_core failed");
    end
    $finish;
  end

endmodule

// ===== folded_hamming_best_match_core.f =====
src/fhbm_pkg.sv
src/fhbm_ram.sv
src/fhbm_scan_unit.sv
src/folded_hamming_best_match_core.sv
test/tb_folded_hamming_best_match_core.sv
